@@ src/dgst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgst_pkg
// shared types and constants of the dual gate speed timer
// ----------------------------------------------------------------------------
package dgst_pkg;

  localparam int SAMPLE_W = 12;
  localparam int COUNT_W  = 24;
  localparam int CFG_W    = 24;
  localparam int INDEX_W  = 3;
  localparam int STATE_W  = 2;

  localparam int MID_DEPTH = 8;
  localparam int OUT_DEPTH = 2;

  localparam logic [SAMPLE_W-1:0] PRESET_LEVEL  = 12'd300;
  localparam logic [SAMPLE_W-1:0] HIGH_RESET    = 12'd150;
  localparam logic [SAMPLE_W-1:0] LOW_RESET     = 12'd100;
  localparam logic [COUNT_W-1:0]  TIMEOUT_RESET = 24'd112500;

  localparam logic [INDEX_W-1:0] REG_HIGH_CH0 = 3'd0;
  localparam logic [INDEX_W-1:0] REG_HIGH_CH1 = 3'd1;
  localparam logic [INDEX_W-1:0] REG_LOW_CH0  = 3'd2;
  localparam logic [INDEX_W-1:0] REG_LOW_CH1  = 3'd3;
  localparam logic [INDEX_W-1:0] REG_TIMEOUT  = 3'd4;

  typedef struct packed {
    logic [SAMPLE_W-1:0] high_ch0;
    logic [SAMPLE_W-1:0] high_ch1;
    logic [SAMPLE_W-1:0] low_ch0;
    logic [SAMPLE_W-1:0] low_ch1;
  } thresh_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered_ch0;
    logic [SAMPLE_W-1:0] filtered_ch1;
    logic                active_ch0;
    logic                active_ch1;
  } level_word_t;

  typedef struct packed {
    level_word_t         level;
    logic [STATE_W-1:0]  measure_state;
    logic                start_channel;
    logic [COUNT_W-1:0]  period_count;
    logic                period_done;
    logic                timed_out;
  } result_t;

endpackage

@@ src/dgst_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgst_fifo
// small synchronous word queue, head shown while not empty
// ----------------------------------------------------------------------------
module dgst_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             wr_en, rd_en;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));
  assign wr_en    = push && !full;
  assign rd_en    = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count_r <= count_r + CW'(1);
      end else if (rd_en && !wr_en) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

@@ src/dgst_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgst_front
// boxcar average and hysteresis of both gate channels, one word a cycle
// ----------------------------------------------------------------------------
module dgst_front #(
  parameter int AVERAGE_LENGTH = 16,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            take,
  input  logic [dgst_pkg::SAMPLE_W-1:0]   sample_ch0,
  input  logic [dgst_pkg::SAMPLE_W-1:0]   sample_ch1,
  input  dgst_pkg::thresh_t               thresh,
  output logic                            word_valid,
  output dgst_pkg::level_word_t           word
);

  localparam int SW     = dgst_pkg::SAMPLE_W;
  localparam int LG     = $clog2(AVERAGE_LENGTH);
  localparam int PW     = (LG > 0) ? LG : 1;
  localparam int SUM_W  = SW + LG;
  localparam int SHIFT  = SUM_W + LG;
  localparam int RW     = SUM_W + 1;
  localparam int PRW    = SUM_W + RW;
  localparam int KEEP   = (SAMPLE_BITS < SW) ? SAMPLE_BITS : SW;
  localparam logic [SW:0] MASK_WIDE = (({{SW{1'b0}}, 1'b1}) << KEEP) - 1;
  localparam logic [SW-1:0] SMASK = MASK_WIDE[SW-1:0];
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SHIFT) + 64'(AVERAGE_LENGTH) - 64'd1) / 64'(AVERAGE_LENGTH);
  localparam logic [RW-1:0]    RECIP     = RECIP64[RW-1:0];
  localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(300 * AVERAGE_LENGTH);

  // ring of past sample pairs, preset level served until the first wrap
  logic [2*SW-1:0] ring_mem [AVERAGE_LENGTH];
  logic [2*SW-1:0] ring_rd_r;
  logic [PW-1:0]   pos_r;
  logic            ring_full_r;

  logic [SW-1:0]    s0_r, s1_r;
  logic             preset_r;
  logic             v1_r, v2_r, v3_r;
  logic [SUM_W-1:0] sum0_r, sum1_r;
  logic [PRW-1:0]   prod0_r, prod1_r;
  logic             lvl0_r, lvl1_r;

  logic [SW-1:0] in0, in1, old0, old1, avg0, avg1;
  logic          lvl0_nxt, lvl1_nxt;

  assign in0  = sample_ch0 & SMASK;
  assign in1  = sample_ch1 & SMASK;
  assign old0 = preset_r ? dgst_pkg::PRESET_LEVEL : ring_rd_r[SW-1:0];
  assign old1 = preset_r ? dgst_pkg::PRESET_LEVEL : ring_rd_r[2*SW-1:SW];
  assign avg0 = prod0_r[SHIFT +: SW];
  assign avg1 = prod1_r[SHIFT +: SW];

  always_ff @(posedge clk) begin
    if (take) begin
      ring_mem[pos_r] <= {in1, in0};
      ring_rd_r       <= ring_mem[pos_r];
      s0_r            <= in0;
      s1_r            <= in1;
      preset_r        <= !ring_full_r;
    end
    if (v2_r) begin
      prod0_r <= PRW'(sum0_r) * PRW'(RECIP);
      prod1_r <= PRW'(sum1_r) * PRW'(RECIP);
    end
  end

  always_comb begin
    lvl0_nxt = lvl0_r;
    if (!lvl0_r && (avg0 < thresh.low_ch0)) begin
      lvl0_nxt = 1'b1;
    end else if (avg0 > thresh.high_ch0) begin
      lvl0_nxt = 1'b0;
    end
    lvl1_nxt = lvl1_r;
    if (!lvl1_r && (avg1 < thresh.low_ch1)) begin
      lvl1_nxt = 1'b1;
    end else if (avg1 > thresh.high_ch1) begin
      lvl1_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      ring_full_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      sum0_r      <= SUM_RESET;
      sum1_r      <= SUM_RESET;
      lvl0_r      <= 1'b0;
      lvl1_r      <= 1'b0;
    end else begin
      v1_r <= take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (take) begin
        if (pos_r == PW'(AVERAGE_LENGTH - 1)) begin
          pos_r       <= '0;
          ring_full_r <= 1'b1;
        end else begin
          pos_r <= pos_r + PW'(1);
        end
      end
      if (v1_r) begin
        sum0_r <= sum0_r - SUM_W'(old0) + SUM_W'(s0_r);
        sum1_r <= sum1_r - SUM_W'(old1) + SUM_W'(s1_r);
      end
      if (v3_r) begin
        lvl0_r <= lvl0_nxt;
        lvl1_r <= lvl1_nxt;
      end
    end
  end

  assign word_valid        = v3_r;
  assign word.filtered_ch0 = avg0;
  assign word.filtered_ch1 = avg1;
  assign word.active_ch0   = lvl0_nxt;
  assign word.active_ch1   = lvl1_nxt;

endmodule

@@ src/dgst_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgst_back
// measurement machine: standby, measuring, ending
// ----------------------------------------------------------------------------
module dgst_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           word_valid,
  input  dgst_pkg::level_word_t          word,
  output logic                           word_pop,
  input  logic [dgst_pkg::COUNT_W-1:0]   timeout_limit,
  input  logic                           res_full,
  output logic                           res_push,
  output dgst_pkg::result_t              res
);

  localparam int CW = dgst_pkg::COUNT_W;

  typedef enum logic [dgst_pkg::STATE_W-1:0] {
    ST_STANDBY   = 2'd0,
    ST_MEASURING = 2'd1,
    ST_ENDING    = 2'd2
  } state_t;

  state_t        state_r, state_nxt;
  logic          start_r, start_nxt;
  logic [CW-1:0] count_r, count_nxt, count_inc;
  logic          done, tout, take, opposite;

  assign take      = word_valid && !res_full;
  assign count_inc = count_r + CW'(1);
  assign opposite  = start_r ? word.active_ch0 : word.active_ch1;

  always_comb begin
    state_nxt = state_r;
    start_nxt = start_r;
    count_nxt = count_r;
    done      = 1'b0;
    tout      = 1'b0;
    unique case (state_r)
      ST_STANDBY: begin
        if (word.active_ch0 || word.active_ch1) begin
          start_nxt = !word.active_ch0;
          count_nxt = '0;
          state_nxt = ST_MEASURING;
        end
      end
      ST_MEASURING: begin
        count_nxt = count_inc;
        if (count_inc >= timeout_limit) begin
          count_nxt = '0;
          state_nxt = ST_ENDING;
          tout      = 1'b1;
        end else if (opposite) begin
          state_nxt = ST_ENDING;
          done      = 1'b1;
        end
      end
      default: begin
        if (!word.active_ch0 && !word.active_ch1) begin
          state_nxt = ST_STANDBY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_STANDBY;
      start_r <= 1'b0;
      count_r <= '0;
    end else if (take) begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      count_r <= count_nxt;
    end
  end

  assign word_pop          = take;
  assign res_push          = take;
  assign res.level         = word;
  assign res.measure_state = state_nxt;
  assign res.start_channel = start_nxt;
  assign res.period_count  = count_nxt;
  assign res.period_done   = done;
  assign res.timed_out     = tout;

endmodule

@@ src/dual_gate_speed_timer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_gate_speed_timer
// two-gate light barrier speed timer
// ----------------------------------------------------------------------------
// A word of two gate samples is pushed into the front pipeline (push, full) and
// one result word per input comes out of the result queue (empty, pop).
// Each channel is averaged over the last AVERAGE_LENGTH samples, passed
// through a low-active hysteresis and fed to the measurement machine.
// Thresholds and the timeout are set on the cfg_ port, by the user only while
// the block idles; the block itself does not enforce this. A pushed word is
// registered in the front pipeline and both queues. Throughput: one word per
// cycle while full is low, set by the single-port average ring and machine.
// The front pipeline never stalls; it is admitted by a credit count that
// covers the eight-entry queue in front of the machine, so full rises only
// once that queue and the pipeline hold eight words, i.e. when pop has been
// low for a while. A waiting result does not block new pushes until then.
// Reset (rst_n low, synchronous) restores the register defaults, empties
// both queues and presets the averages to 300 without a clearing pass.
// ----------------------------------------------------------------------------
module dual_gate_speed_timer #(
  parameter int AVERAGE_LENGTH = 16,
  parameter int SAMPLE_BITS    = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  logic [dgst_pkg::SAMPLE_W-1:0]   in_sample_ch0,
  input  logic [dgst_pkg::SAMPLE_W-1:0]   in_sample_ch1,
  output logic                            empty,
  input  logic                            pop,
  output logic [dgst_pkg::SAMPLE_W-1:0]   out_filtered_ch0,
  output logic [dgst_pkg::SAMPLE_W-1:0]   out_filtered_ch1,
  output logic                            out_active_ch0,
  output logic                            out_active_ch1,
  output logic [dgst_pkg::STATE_W-1:0]    out_measure_state,
  output logic                            out_start_channel,
  output logic [dgst_pkg::COUNT_W-1:0]    out_period_count,
  output logic                            out_period_done,
  output logic                            out_timed_out,
  input  logic                            cfg_we,
  input  logic [dgst_pkg::INDEX_W-1:0]    cfg_index,
  input  logic [dgst_pkg::CFG_W-1:0]      cfg_data
);

  localparam int SW  = dgst_pkg::SAMPLE_W;
  localparam int CRW = $clog2(dgst_pkg::MID_DEPTH + 1);

  dgst_pkg::thresh_t            thresh_r;
  logic [dgst_pkg::COUNT_W-1:0] timeout_r;
  logic [CRW-1:0]               credit_r;

  logic                  accept;
  logic                  mid_push, mid_full, mid_empty, mid_pop;
  dgst_pkg::level_word_t mid_in, mid_out;
  logic                  res_push, res_full;
  dgst_pkg::result_t     res_in, res_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r.high_ch0 <= dgst_pkg::HIGH_RESET;
      thresh_r.high_ch1 <= dgst_pkg::HIGH_RESET;
      thresh_r.low_ch0  <= dgst_pkg::LOW_RESET;
      thresh_r.low_ch1  <= dgst_pkg::LOW_RESET;
      timeout_r         <= dgst_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dgst_pkg::REG_HIGH_CH0: thresh_r.high_ch0 <= cfg_data[SW-1:0];
        dgst_pkg::REG_HIGH_CH1: thresh_r.high_ch1 <= cfg_data[SW-1:0];
        dgst_pkg::REG_LOW_CH0:  thresh_r.low_ch0  <= cfg_data[SW-1:0];
        dgst_pkg::REG_LOW_CH1:  thresh_r.low_ch1  <= cfg_data[SW-1:0];
        dgst_pkg::REG_TIMEOUT:  timeout_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  // credits for words in the front pipeline and the middle queue
  assign full   = (credit_r == CRW'(dgst_pkg::MID_DEPTH));
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else if (accept && !mid_pop) begin
      credit_r <= credit_r + CRW'(1);
    end else if (mid_pop && !accept) begin
      credit_r <= credit_r - CRW'(1);
    end
  end

  dgst_front #(
    .AVERAGE_LENGTH (AVERAGE_LENGTH),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (accept),
    .sample_ch0 (in_sample_ch0),
    .sample_ch1 (in_sample_ch1),
    .thresh     (thresh_r),
    .word_valid (mid_push),
    .word       (mid_in)
  );

  dgst_fifo #(
    .WIDTH ($bits(dgst_pkg::level_word_t)),
    .DEPTH (dgst_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_data (mid_in),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_out),
    .empty     (mid_empty)
  );

  dgst_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .word_valid    (!mid_empty),
    .word          (mid_out),
    .word_pop      (mid_pop),
    .timeout_limit (timeout_r),
    .res_full      (res_full),
    .res_push      (res_push),
    .res           (res_in)
  );

  dgst_fifo #(
    .WIDTH ($bits(dgst_pkg::result_t)),
    .DEPTH (dgst_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_out),
    .empty     (empty)
  );

  assign out_filtered_ch0  = res_out.level.filtered_ch0;
  assign out_filtered_ch1  = res_out.level.filtered_ch1;
  assign out_active_ch0    = res_out.level.active_ch0;
  assign out_active_ch1    = res_out.level.active_ch1;
  assign out_measure_state = res_out.measure_state;
  assign out_start_channel = res_out.start_channel;
  assign out_period_count  = res_out.period_count;
  assign out_period_done   = res_out.period_done;
  assign out_timed_out     = res_out.timed_out;

  // credits never run past the middle queue
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CRW'(dgst_pkg::MID_DEPTH))
    else $error("credit count above queue depth");

  // front output never meets a full middle queue
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(mid_push && mid_full))
    else $error("middle queue overrun");

  // a word ends a measurement one way only
  a_one_ending: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_period_done && out_timed_out))
    else $error("period done and timeout together");

  // a timeout leaves a cleared count
  a_timeout_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_timed_out) |-> (out_period_count == '0))
    else $error("count kept on timeout");

endmodule

@@ tb/sv/tb_dual_gate_speed_timer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_gate_speed_timer
// self-checking bench for the two-gate light barrier speed timer
// ----------------------------------------------------------------------------
// Sample pairs are pushed into the block and each result word is compared
// field by field with a bit-accurate in-bench model of the averaging,
// hysteresis and measurement machine. A short directed part hits the sample
// and register extremes, crossed thresholds, zero timeout and ignored register
// indexes. Then random beam-crossing sequences run under several threshold and
// timeout settings, with random stalls on both sides and one long pop hold-off
// that fills the block.
// ----------------------------------------------------------------------------
module tb_dual_gate_speed_timer;
  import dgst_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int AVG_LEN    = 16;
  localparam int LATENCY    = 4;
  localparam int HOLD_LEN   = 150;
  localparam int LIMIT_NS   = 10_000_000;

  localparam logic [INDEX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic [STATE_W-1:0] {
    MS_STANDBY   = 2'd0,
    MS_MEASURING = 2'd1,
    MS_ENDING    = 2'd2
  } measure_state_e;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                push          = 1'b0;
  logic                full;
  logic [SAMPLE_W-1:0] in_sample_ch0 = '0;
  logic [SAMPLE_W-1:0] in_sample_ch1 = '0;
  logic                empty;
  logic                pop           = 1'b0;
  logic [SAMPLE_W-1:0] out_filtered_ch0;
  logic [SAMPLE_W-1:0] out_filtered_ch1;
  logic                out_active_ch0;
  logic                out_active_ch1;
  logic [STATE_W-1:0]  out_measure_state;
  logic                out_start_channel;
  logic [COUNT_W-1:0]  out_period_count;
  logic                out_period_done;
  logic                out_timed_out;
  logic                cfg_we        = 1'b0;
  logic [INDEX_W-1:0]  cfg_index     = '0;
  logic [CFG_W-1:0]    cfg_data      = '0;

  // register mirror
  logic [SAMPLE_W-1:0] high_th [2];
  logic [SAMPLE_W-1:0] low_th [2];
  logic [COUNT_W-1:0]  timeout_th;

  // model state
  logic [SAMPLE_W-1:0] ring_mem [2][AVG_LEN];
  logic [15:0]         sum_acc [2];
  int unsigned         ring_ptr;
  logic [1:0]          beam_cut;
  measure_state_e      meas_st;
  logic                starter;
  logic [COUNT_W-1:0]  elapsed;

  result_t expected_words[$];
  int      mismatches    = 0;
  int      word_no       = 0;
  int      send_idle_pct = 0;
  int      pop_idle_pct  = 0;
  logic    hold_req      = 1'b0;
  int      hold_cycles   = 0;

  dual_gate_speed_timer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_sample_ch0     (in_sample_ch0),
    .in_sample_ch1     (in_sample_ch1),
    .empty             (empty),
    .pop               (pop),
    .out_filtered_ch0  (out_filtered_ch0),
    .out_filtered_ch1  (out_filtered_ch1),
    .out_active_ch0    (out_active_ch0),
    .out_active_ch1    (out_active_ch1),
    .out_measure_state (out_measure_state),
    .out_start_channel (out_start_channel),
    .out_period_count  (out_period_count),
    .out_period_done   (out_period_done),
    .out_timed_out     (out_timed_out),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic predict_gate_word(input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1);
    logic [SAMPLE_W-1:0] smp [2];
    logic [SAMPLE_W-1:0] avg [2];
    logic                done;
    logic                tout;
    result_t             r;
    int                  c;
    smp[0] = s0;
    smp[1] = s1;
    done   = 1'b0;
    tout   = 1'b0;
    for (c = 0; c < 2; c++) begin
      sum_acc[c] = sum_acc[c] - ring_mem[c][ring_ptr] + smp[c];
      ring_mem[c][ring_ptr] = smp[c];
      avg[c] = SAMPLE_W'(sum_acc[c] / AVG_LEN);
      if (!beam_cut[c] && avg[c] < low_th[c]) begin
        beam_cut[c] = 1'b1;
      end else if (avg[c] > high_th[c]) begin
        beam_cut[c] = 1'b0;
      end
    end
    ring_ptr = (ring_ptr + 1) % AVG_LEN;
    case (meas_st)
      MS_STANDBY: begin
        if (beam_cut[0] || beam_cut[1]) begin
          starter = !beam_cut[0];
          elapsed = '0;
          meas_st = MS_MEASURING;
        end
      end
      MS_MEASURING: begin
        elapsed = elapsed + 1'b1;
        if (elapsed >= timeout_th) begin
          elapsed = '0;
          meas_st = MS_ENDING;
          tout    = 1'b1;
        end else if (beam_cut[starter ^ 1'b1]) begin
          meas_st = MS_ENDING;
          done    = 1'b1;
        end
      end
      default: begin
        if (!beam_cut[0] && !beam_cut[1]) meas_st = MS_STANDBY;
      end
    endcase
    r.level.filtered_ch0 = avg[0];
    r.level.filtered_ch1 = avg[1];
    r.level.active_ch0   = beam_cut[0];
    r.level.active_ch1   = beam_cut[1];
    r.measure_state      = meas_st;
    r.start_channel      = starter;
    r.period_count       = elapsed;
    r.period_done        = done;
    r.timed_out          = tout;
    expected_words.push_back(r);
  endtask

  task automatic check_field(input string fname, input logic [COUNT_W-1:0] want_v,
                             input logic [COUNT_W-1:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("word %0d %s mismatch: expected %0d, got %0d", word_no, fname, want_v, got_v);
    end
  endtask

  task automatic check_gate_word();
    result_t want;
    word_no++;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("word %0d arrived with nothing expected", word_no);
    end else begin
      want = expected_words.pop_front();
      check_field("filtered_ch0", want.level.filtered_ch0, out_filtered_ch0);
      check_field("filtered_ch1", want.level.filtered_ch1, out_filtered_ch1);
      check_field("active_ch0", want.level.active_ch0, out_active_ch0);
      check_field("active_ch1", want.level.active_ch1, out_active_ch1);
      check_field("measure_state", want.measure_state, out_measure_state);
      check_field("start_channel", want.start_channel, out_start_channel);
      check_field("period_count", want.period_count, out_period_count);
      check_field("period_done", want.period_done, out_period_done);
      check_field("timed_out", want.timed_out, out_timed_out);
    end
  endtask

  // result side: check on accept, random pop stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_gate_word();
      if (hold_req) pop <= 1'b0;
      else pop <= ($urandom_range(99) >= pop_idle_pct);
    end
  end

  // long pop hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      if (hold_cycles == HOLD_LEN - 1) begin
        hold_req    <= 1'b0;
        hold_cycles <= 0;
      end else begin
        hold_cycles <= hold_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HIGH_CH0: high_th[0] = val[SAMPLE_W-1:0];
      REG_HIGH_CH1: high_th[1] = val[SAMPLE_W-1:0];
      REG_LOW_CH0:  low_th[0]  = val[SAMPLE_W-1:0];
      REG_LOW_CH1:  low_th[1]  = val[SAMPLE_W-1:0];
      REG_TIMEOUT:  timeout_th = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_pair(input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    in_sample_ch0 <= s0;
    in_sample_ch1 <= s1;
    do @(posedge clk); while (full);
    predict_gate_word(s0, s1);
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] gate_sample(input int c, input bit dark);
    int lo;
    int hi;
    lo = low_th[c];
    hi = high_th[c];
    if (dark) return (lo == 0) ? '0 : SAMPLE_W'($urandom_range(lo - 1, 0));
    return (hi >= 4095) ? '1 : SAMPLE_W'($urandom_range(4095, hi + 1));
  endfunction

  task automatic random_config();
    logic [SAMPLE_W-1:0] lo0;
    logic [SAMPLE_W-1:0] lo1;
    lo0 = SAMPLE_W'($urandom_range(1500, 50));
    lo1 = SAMPLE_W'($urandom_range(1500, 50));
    write_reg(REG_LOW_CH0, CFG_W'(lo0));
    write_reg(REG_LOW_CH1, CFG_W'(lo1));
    write_reg(REG_HIGH_CH0, CFG_W'(lo0 + $urandom_range(1500)));
    write_reg(REG_HIGH_CH1, CFG_W'(lo1 + $urandom_range(1500)));
    case ($urandom_range(3))
      0:       write_reg(REG_TIMEOUT, CFG_W'($urandom_range(40, 1)));
      1:       write_reg(REG_TIMEOUT, CFG_W'($urandom_range(300, 41)));
      2:       write_reg(REG_TIMEOUT, CFG_W'(TIMEOUT_RESET));
      default: write_reg(REG_TIMEOUT, {CFG_W{1'b1}});
    endcase
  endtask

  // beam crossings: lead-in, first gate dark, second gate dark after a lag,
  // tail to release; some with the second gate never cut, some raw noise
  task automatic run_transits(input int n_items);
    int sent;
    int lead;
    int dark_a;
    int lag;
    int dark_b;
    int span;
    int t;
    bit first_ch;
    bit broken;
    bit dark_first;
    bit dark_second;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        repeat ($urandom_range(8, 1)) begin
          send_pair(SAMPLE_W'($urandom_range(4095)), SAMPLE_W'($urandom_range(4095)));
          sent++;
        end
      end else begin
        lead     = $urandom_range(24);
        dark_a   = $urandom_range(48, 4);
        lag      = $urandom_range(40);
        dark_b   = $urandom_range(48, 4);
        broken   = ($urandom_range(99) < 20);
        first_ch = $urandom_range(1);
        span     = lead + dark_a + lag + dark_b + 24;
        for (t = 0; t < span && sent < n_items; t++) begin
          dark_first  = (t >= lead) && (t < lead + dark_a);
          dark_second = !broken && (t >= lead + lag) && (t < lead + lag + dark_b);
          if (first_ch)
            send_pair(gate_sample(0, dark_second), gate_sample(1, dark_first));
          else
            send_pair(gate_sample(0, dark_first), gate_sample(1, dark_second));
          sent++;
        end
      end
    end
  endtask

  task automatic test_sample_extremes();
    send_pair('0, '1);
    send_pair('1, '0);
    send_pair('1, '1);
    send_pair('0, '0);
    send_pair('0, '0);
    send_pair('1, '1);
    wait_drain();
  endtask

  // low above high on both channels: toggling levels, ch0 wins the start,
  // every measuring word times out; upper data bits and spare indexes ignored
  task automatic test_crossed_thresholds();
    write_reg(REG_HIGH_CH0, 24'hFFF000);
    write_reg(REG_HIGH_CH1, 24'h000000);
    write_reg(REG_LOW_CH0, 24'h000FFF);
    write_reg(REG_LOW_CH1, 24'hABCFFF);
    write_reg(REG_TIMEOUT, 24'h000000);
    write_reg(REG_SPARE_LO, 24'h000001);
    write_reg(REG_SPARE_HI, 24'hFFFFFF);
    repeat (8) send_pair(SAMPLE_W'($urandom_range(4095)), SAMPLE_W'($urandom_range(4095)));
    wait_drain();
  endtask

  task automatic test_timeout_extremes();
    // ch0 always cut, ch1 never: one-word timeout then stuck ending
    write_reg(REG_TIMEOUT, 24'd1);
    write_reg(REG_HIGH_CH0, 24'd4095);
    write_reg(REG_LOW_CH0, 24'd4095);
    write_reg(REG_HIGH_CH1, 24'd0);
    write_reg(REG_LOW_CH1, 24'd0);
    repeat (3) send_pair(SAMPLE_W'($urandom_range(4094)), SAMPLE_W'($urandom_range(4095)));
    wait_drain();
    // both released, back to standby
    write_reg(REG_HIGH_CH0, 24'd0);
    write_reg(REG_LOW_CH0, 24'd0);
    repeat (2) send_pair(SAMPLE_W'($urandom_range(4095, 1)), SAMPLE_W'($urandom_range(4095, 1)));
    wait_drain();
    // ch1 starts, long timeout
    write_reg(REG_TIMEOUT, {CFG_W{1'b1}});
    write_reg(REG_HIGH_CH1, 24'd4095);
    write_reg(REG_LOW_CH1, 24'd4095);
    repeat (3) send_pair(SAMPLE_W'($urandom_range(4095, 1)), SAMPLE_W'($urandom_range(4094)));
    wait_drain();
    // ch0 cut stops the period
    write_reg(REG_HIGH_CH0, 24'd4095);
    write_reg(REG_LOW_CH0, 24'd4095);
    repeat (2) send_pair(SAMPLE_W'($urandom_range(4094)), SAMPLE_W'($urandom_range(4094)));
    wait_drain();
  endtask

  task automatic test_full_backpressure();
    random_config();
    send_idle_pct = 0;
    pop_idle_pct <= 0;
    hold_req     <= 1'b1;
    run_transits(40);
    wait_drain();
  endtask

  task automatic test_random_traffic(input int s_idle, input int r_idle, input int n_items);
    send_idle_pct = s_idle;
    pop_idle_pct <= r_idle;
    repeat (2) begin
      random_config();
      run_transits(n_items / 2);
      wait_drain();
    end
  endtask

  initial begin
    int c;
    int i;
    high_th[0] = HIGH_RESET;
    high_th[1] = HIGH_RESET;
    low_th[0]  = LOW_RESET;
    low_th[1]  = LOW_RESET;
    timeout_th = TIMEOUT_RESET;
    for (c = 0; c < 2; c++) begin
      for (i = 0; i < AVG_LEN; i++) ring_mem[c][i] = PRESET_LEVEL;
      sum_acc[c] = 16'(PRESET_LEVEL * AVG_LEN);
    end
    ring_ptr = 0;
    beam_cut = '0;
    meas_st  = MS_STANDBY;
    starter  = 1'b0;
    elapsed  = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_sample_extremes();
    test_crossed_thresholds();
    test_timeout_extremes();
    test_full_backpressure();
    test_random_traffic(7, 51, 180);
    test_random_traffic(51, 7, 180);
    test_random_traffic(0, 0, 180);

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
